@@ sv/t8cpu_pkg.sv @@
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Shared constants and types of the tiny 8-bit CPU fetch/execute unit.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

    // Default code store depth in words.
    localparam int CODE_DEPTH_DEF = 64;

    // Field widths.
    localparam int PC_W   = 6;
    localparam int DATA_W = 8;
    localparam int WORD_W = 9;
    localparam int CNT_W  = 32;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // ALU operation codes.
    localparam logic [2:0] ALU_ADD   = 3'd0;
    localparam logic [2:0] ALU_XOR   = 3'd1;
    localparam logic [2:0] ALU_AND   = 3'd2;
    localparam logic [2:0] ALU_OR    = 3'd3;
    localparam logic [2:0] ALU_PASSX = 3'd4;
    localparam logic [2:0] ALU_PASSY = 3'd5;

    // Destination register codes.
    localparam logic [1:0] DST_X0 = 2'd0;
    localparam logic [1:0] DST_X1 = 2'd1;
    localparam logic [1:0] DST_Y0 = 2'd2;
    localparam logic [1:0] DST_Y1 = 2'd3;

    // Miscellaneous instruction codes (low three bits).
    localparam logic [2:0] MISC_HALT = 3'd0;
    localparam logic [2:0] MISC_CLC  = 3'd1;

    // ALU evaluation result with its flags.
    typedef struct packed {
        logic              carry;
        logic              zero;
        logic [DATA_W-1:0] result;
    } alu_out_t;

endpackage

@@ sv/t8cpu_ram.sv @@
// ----------------------------------------------------------------------------
// t8cpu_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module t8cpu_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered reads return the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ sv/tiny_8bit_cpu_fetch_execute_unit.sv @@
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_fetch_execute_unit
// Small 8-bit CPU with four registers and a 9-bit code store, driven by a
// stream of load and step items.
// ----------------------------------------------------------------------------
// Each input beat either writes one code word (tuser low) or executes one
// instruction (tuser high), and produces one output beat with the machine
// state after it. The unit takes one beat per clock cycle when the output
// side is ready. The code store is a RAM with registered reads: while an
// instruction executes, the address of the following instruction (and of
// the word after it, for load-immediate) is computed and read, so the
// fetched words are ready in the next cycle; code loads to those addresses
// are forwarded. Per-word valid bits make the store read as zero after
// reset without a clearing pass.
module tiny_8bit_cpu_fetch_execute_unit #(
    parameter int CODE_DEPTH = t8cpu_pkg::CODE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // load_addr[5:0], load_word[14:6], zero pad
    input  logic        s_tuser,   // opcode
    // Output beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // pc[5:0], x0[13:6], x1[21:14], y0[29:22],
                                   // y1[37:30], carry[38], zero[39],
                                   // halted[40], cycles[72:41], zero pad
);

    localparam int AW = $clog2(CODE_DEPTH);
    localparam int PW = t8cpu_pkg::PC_W;
    localparam int DW = t8cpu_pkg::DATA_W;
    localparam int WW = t8cpu_pkg::WORD_W;
    localparam int CW = t8cpu_pkg::CNT_W;

    // Reduce a program address modulo the code store depth.
    function automatic logic [AW-1:0] code_index(input logic [PW-1:0] a);
        logic [8:0] v;
        v = {{(9-PW){1'b0}}, a};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 9'(CODE_DEPTH))
            begin
                v = v - 9'(CODE_DEPTH);
            end
        end
        return v[AW-1:0];
    endfunction

    // ALU evaluation from an operation, bank selects and the registers.
    function automatic t8cpu_pkg::alu_out_t alu_eval(
        input logic [2:0]    sel,
        input logic          bx,
        input logic          by,
        input logic [DW-1:0] x0,
        input logic [DW-1:0] x1,
        input logic [DW-1:0] y0,
        input logic [DW-1:0] y1
    );
        t8cpu_pkg::alu_out_t o;
        logic [DW-1:0]       a;
        logic [DW-1:0]       b;
        logic [DW:0]         sum;
        a   = bx ? x1 : x0;
        b   = by ? y1 : y0;
        sum = {1'b0, a} + {1'b0, b};
        o.carry = 1'b0;
        case (sel)
            t8cpu_pkg::ALU_ADD:
            begin
                o.result = sum[DW-1:0];
                o.carry  = sum[DW];
            end
            t8cpu_pkg::ALU_XOR:   o.result = a ^ b;
            t8cpu_pkg::ALU_AND:   o.result = a & b;
            t8cpu_pkg::ALU_OR:    o.result = a | b;
            t8cpu_pkg::ALU_PASSX: o.result = a;
            default:              o.result = b;
        endcase
        o.zero = (o.result == '0);
        return o;
    endfunction

    // Machine state; it also serves as the output register.
    logic [PW-1:0] pc_reg,    pc_next;
    logic [DW-1:0] x0_reg,    x0_next;
    logic [DW-1:0] x1_reg,    x1_next;
    logic [DW-1:0] y0_reg,    y0_next;
    logic [DW-1:0] y1_reg,    y1_next;
    logic [2:0]    sel_reg,   sel_next;
    logic          bx_reg,    bx_next;
    logic          by_reg,    by_next;
    logic          carry_reg, carry_next;
    logic          zero_reg,  zero_next;
    logic          halt_reg,  halt_next;
    logic [CW-1:0] cycle_reg, cycle_next;
    logic          m_valid_reg;

    // Code store read side.
    logic [CODE_DEPTH-1:0] valid_reg;
    logic                  fwd0_reg, fwd1_reg;
    logic                  vld0_reg, vld1_reg;
    logic [WW-1:0]         fwd_word_reg;
    logic [WW-1:0]         ram_rd0, ram_rd1;
    logic [WW-1:0]         word0, word1;
    logic [AW-1:0]         rd_addr0, rd_addr1;
    logic [AW-1:0]         wr_addr;
    logic                  ram_we;

    logic                  s_fire;
    logic [PW-1:0]         load_addr;
    logic [WW-1:0]         load_word;
    logic                  jflag;
    t8cpu_pkg::alu_out_t   alu_res;
    t8cpu_pkg::alu_out_t   alu_flags;

    assign load_addr = s_tdata[5:0];
    assign load_word = s_tdata[14:6];

    // Handshake: the state registers hold the result until it is taken.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, cycle_reg, halt_reg, zero_reg, carry_reg,
                       y1_reg, y0_reg, x1_reg, x0_reg, pc_reg};

    // Fetched words: forwarded load data, stored data, or zero if unwritten.
    assign word0 = fwd0_reg ? fwd_word_reg : (vld0_reg ? ram_rd0 : '0);
    assign word1 = fwd1_reg ? fwd_word_reg : (vld1_reg ? ram_rd1 : '0);

    // Instruction execution.
    always_comb
    begin
        pc_next    = pc_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        sel_next   = sel_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        carry_next = carry_reg;
        zero_next  = zero_reg;
        halt_next  = halt_reg;
        cycle_next = cycle_reg;
        ram_we     = 1'b0;
        jflag      = word0[6] ? zero_reg : carry_reg;
        alu_res    = alu_eval(word0[4:2], word0[6], word0[5],
                              x0_reg, x1_reg, y0_reg, y1_reg);
        alu_flags  = '0;
        if (s_fire)
        begin
            if (s_tuser == t8cpu_pkg::OP_LOAD)
            begin
                ram_we = 1'b1;
            end
            else if (!halt_reg)
            begin
                pc_next    = pc_reg + PW'(1);
                cycle_next = cycle_reg + CW'(1);
                if (word0[8])
                begin
                    // Conditional jump, taken when the flag differs from the not bit.
                    if (jflag != word0[7])
                    begin
                        pc_next = word0[5:0];
                    end
                end
                else if (word0[7])
                begin
                    // ALU operation with bank selects and a destination.
                    if (word0[4:2] > t8cpu_pkg::ALU_PASSY)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        bx_next  = word0[6];
                        by_next  = word0[5];
                        sel_next = word0[4:2];
                        case (word0[1:0])
                            t8cpu_pkg::DST_X0: x0_next = alu_res.result;
                            t8cpu_pkg::DST_X1: x1_next = alu_res.result;
                            t8cpu_pkg::DST_Y0: y0_next = alu_res.result;
                            default:           y1_next = alu_res.result;
                        endcase
                        alu_flags  = alu_eval(sel_next, bx_next, by_next,
                                              x0_next, x1_next, y0_next, y1_next);
                        carry_next = alu_flags.carry;
                        zero_next  = alu_flags.zero;
                    end
                end
                else if (word0[6])
                begin
                    pc_next = word0[5:0];
                end
                else if (word0[5])
                begin
                    halt_next = 1'b1;
                end
                else if (word0[4])
                begin
                    // Load immediate from the next word into the masked registers.
                    if (word0[0])
                    begin
                        x0_next = word1[DW-1:0];
                    end
                    if (word0[1])
                    begin
                        x1_next = word1[DW-1:0];
                    end
                    if (word0[2])
                    begin
                        y0_next = word1[DW-1:0];
                    end
                    if (word0[3])
                    begin
                        y1_next = word1[DW-1:0];
                    end
                    alu_flags  = alu_eval(sel_reg, bx_reg, by_reg,
                                          x0_next, x1_next, y0_next, y1_next);
                    carry_next = alu_flags.carry;
                    zero_next  = alu_flags.zero;
                    pc_next    = pc_reg + PW'(2);
                end
                else if (word0[2:0] == t8cpu_pkg::MISC_CLC)
                begin
                    carry_next = 1'b0;
                end
                else
                begin
                    halt_next = 1'b1;
                end
            end
        end
    end

    // Fetch addresses follow the next program counter.
    assign rd_addr0 = code_index(pc_next);
    assign rd_addr1 = code_index(pc_next + PW'(1));
    assign wr_addr  = code_index(load_addr);

    t8cpu_ram #(
        .WIDTH (WW),
        .DEPTH (CODE_DEPTH)
    ) u_code (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (wr_addr),
        .wdata   (load_word),
        .raddr_a (rd_addr0),
        .rdata_a (ram_rd0),
        .raddr_b (rd_addr1),
        .rdata_b (ram_rd1)
    );

    // Forwarding and valid tracking for the registered reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd0_reg  <= 1'b0;
            fwd1_reg  <= 1'b0;
            vld0_reg  <= 1'b0;
            vld1_reg  <= 1'b0;
        end
        else
        begin
            fwd0_reg <= ram_we && (wr_addr == rd_addr0);
            fwd1_reg <= ram_we && (wr_addr == rd_addr1);
            vld0_reg <= valid_reg[rd_addr0];
            vld1_reg <= valid_reg[rd_addr1];
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_word_reg <= load_word;
    end

    // Machine state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            x0_reg      <= '0;
            x1_reg      <= '0;
            y0_reg      <= '0;
            y1_reg      <= '0;
            sel_reg     <= t8cpu_pkg::ALU_ADD;
            bx_reg      <= 1'b0;
            by_reg      <= 1'b0;
            carry_reg   <= 1'b0;
            zero_reg    <= 1'b1;
            halt_reg    <= 1'b0;
            cycle_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            x0_reg      <= x0_next;
            x1_reg      <= x1_next;
            y0_reg      <= y0_next;
            y1_reg      <= y1_next;
            sel_reg     <= sel_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            carry_reg   <= carry_next;
            zero_reg    <= zero_next;
            halt_reg    <= halt_next;
            cycle_reg   <= cycle_next;
            if (s_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ tb/tiny_8bit_cpu_fetch_execute_unit_tb.sv @@
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_fetch_execute_unit_tb
// Self-checking testbench of the tiny 8-bit CPU fetch/execute unit.
// ----------------------------------------------------------------------------
// A short table of load and step beats runs a small program through every
// ALU operation, a taken branch, clear-carry, an empty load-immediate and a
// jump. Then the whole code store is filled with words that never halt, and
// random runs of steps, code loads near the program counter, overwritten
// junk words and load-immediate sequences follow. The run ends with a single
// randomly chosen halting word, steps while halted and a load while halted.
// Every output beat is compared field by field with the hand-typed state of
// its row, if it has one, or else with a shadow copy of the machine that is
// advanced on each accepted input beat. Both sides stall at random.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_fetch_execute_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Instruction class bits, highest first match.
    localparam logic [8:0] CLS_BRANCH = 9'h100;
    localparam logic [8:0] CLS_ALU    = 9'h080;
    localparam logic [8:0] CLS_JUMP   = 9'h040;
    localparam logic [8:0] CLS_BAD    = 9'h020;
    localparam logic [8:0] CLS_LDI    = 9'h010;

    localparam int DIRECTED_ROWS = 25;
    localparam int TOTAL_ITEMS   = 1245;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 20;

    // Machine state reported with every output beat.
    typedef struct packed {
        logic [5:0]  pc;
        logic [7:0]  x0;
        logic [7:0]  x1;
        logic [7:0]  y0;
        logic [7:0]  y1;
        logic        carry;
        logic        zero;
        logic        halted;
        logic [31:0] cycles;
    } cpu_state_t;

    // One input beat, with an optional hand-typed expected state.
    typedef struct packed {
        logic       op;
        logic [5:0] addr;
        logic [8:0] word;
        logic       typed;
        cpu_state_t exp;
    } stim_row_t;

    localparam cpu_state_t RESET_STATE = '{pc: 6'd0, x0: 8'd0, x1: 8'd0, y0: 8'd0,
                                           y1: 8'd0, carry: 1'b0, zero: 1'b1,
                                           halted: 1'b0, cycles: 32'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    tiny_8bit_cpu_fetch_execute_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the machine.
    logic [8:0]  code_image [64];
    logic [7:0]  reg_image [4];
    logic [5:0]  pc_image;
    logic [2:0]  alu_sel_image;
    logic        bank_x_image;
    logic        bank_y_image;
    logic        carry_image;
    logic        zero_image;
    logic        halt_image;
    logic [31:0] cycle_image;

    cpu_state_t  expected_states [$];
    stim_row_t   pending_rows [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];
    int          error_count = 0;
    int          item_count = 0;
    int          tb_cycles = 0;
    bit          calm = 1'b0;
    int          ready_hold = 0;

    // Clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Reset asserted at start and released once.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Wait drawn for each beat; none during calm stretches.
    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // Instruction word builders.
    function automatic logic [8:0] alu_word(input logic xb, input logic yb,
                                            input logic [2:0] op, input logic [1:0] dst);
        return CLS_ALU | {2'b00, xb, yb, op, dst};
    endfunction

    function automatic logic [8:0] branch_word(input logic inv, input logic on_zero,
                                               input logic [5:0] target);
        return CLS_BRANCH | {1'b0, inv, on_zero, target};
    endfunction

    function automatic logic [8:0] jump_word(input logic [5:0] target);
        return CLS_JUMP | {3'b000, target};
    endfunction

    function automatic logic [8:0] ldi_word(input logic [3:0] mask);
        return CLS_LDI | {5'b00000, mask};
    endfunction

    function automatic logic [8:0] clc_word(input logic spare);
        return {5'b00000, spare, t8cpu_pkg::MISC_CLC};
    endfunction

    // A word that never stops the machine when executed.
    function automatic logic [8:0] safe_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return alu_word(1'($urandom), 1'($urandom),
                            3'($urandom_range(t8cpu_pkg::ALU_ADD, t8cpu_pkg::ALU_PASSY)),
                            2'($urandom_range(t8cpu_pkg::DST_X0, t8cpu_pkg::DST_Y1)));
        if (pick < 6)
            return CLS_BRANCH | 9'($urandom_range(0, 255));
        if (pick == 6)
            return jump_word(6'($urandom));
        if (pick < 9)
            return ldi_word(4'($urandom));
        return clc_word(1'($urandom));
    endfunction

    // A word that halts the machine, of a random kind.
    function automatic logic [8:0] halting_word();
        logic [2:0] low3;
        logic [2:0] op;
        case ($urandom_range(0, 3))
            0: return {5'b00000, 1'($urandom), t8cpu_pkg::MISC_HALT};
            1:
            begin
                low3 = 3'($urandom);
                while (low3 == t8cpu_pkg::MISC_HALT || low3 == t8cpu_pkg::MISC_CLC)
                    low3 = 3'($urandom);
                return {5'b00000, 1'($urandom), low3};
            end
            2: return CLS_BAD | 9'($urandom_range(0, 31));
            default:
            begin
                op = 3'($urandom);
                while (op <= t8cpu_pkg::ALU_PASSY)
                    op = 3'($urandom);
                return alu_word(1'($urandom), 1'($urandom), op, 2'($urandom));
            end
        endcase
    endfunction

    // ALU result of the current select and banks; carry and zero follow it.
    function automatic logic [7:0] alu_refresh();
        logic [7:0] a;
        logic [7:0] b;
        logic [8:0] sum;
        logic [7:0] r;
        logic       c;
        a = reg_image[{1'b0, bank_x_image}];
        b = reg_image[{1'b1, bank_y_image}];
        sum = {1'b0, a} + {1'b0, b};
        c = 1'b0;
        case (alu_sel_image)
            t8cpu_pkg::ALU_ADD:
            begin
                r = sum[7:0];
                c = sum[8];
            end
            t8cpu_pkg::ALU_XOR:   r = a ^ b;
            t8cpu_pkg::ALU_AND:   r = a & b;
            t8cpu_pkg::ALU_OR:    r = a | b;
            t8cpu_pkg::ALU_PASSX: r = a;
            default:              r = b;
        endcase
        carry_image = c;
        zero_image = (r == 8'd0);
        return r;
    endfunction

    function automatic void write_regs(input logic [3:0] mask, input logic [7:0] val);
        for (int i = 0; i < 4; i++)
            if (mask[i])
                reg_image[i] = val;
        void'(alu_refresh());
    endfunction

    // Advances the shadow machine by one beat and returns the reported state.
    function automatic cpu_state_t predict_cpu_step(input logic op, input logic [5:0] addr,
                                                    input logic [8:0] word);
        logic [8:0] w;
        logic       flag;
        logic [7:0] res;
        cpu_state_t st;
        if (op == t8cpu_pkg::OP_LOAD)
        begin
            code_image[addr] = word;
        end
        else if (!halt_image)
        begin
            w = code_image[pc_image];
            pc_image = pc_image + 6'd1;
            cycle_image = cycle_image + 32'd1;
            if ((w & CLS_BRANCH) != '0)
            begin
                // Taken when the tested flag differs from the not bit.
                flag = w[6] ? zero_image : carry_image;
                if (flag != w[7])
                    pc_image = w[5:0];
            end
            else if ((w & CLS_ALU) != '0)
            begin
                if (w[4:2] > t8cpu_pkg::ALU_PASSY)
                begin
                    halt_image = 1'b1;
                end
                else
                begin
                    bank_x_image = w[6];
                    bank_y_image = w[5];
                    alu_sel_image = w[4:2];
                    res = alu_refresh();
                    write_regs(4'b0001 << w[1:0], res);
                end
            end
            else if ((w & CLS_JUMP) != '0)
            begin
                pc_image = w[5:0];
            end
            else if ((w & CLS_BAD) != '0)
            begin
                halt_image = 1'b1;
            end
            else if ((w & CLS_LDI) != '0)
            begin
                // The immediate is the next word, which is then skipped.
                write_regs(w[3:0], code_image[pc_image][7:0]);
                pc_image = pc_image + 6'd1;
            end
            else if (w[2:0] == t8cpu_pkg::MISC_CLC)
            begin
                carry_image = 1'b0;
            end
            else
            begin
                halt_image = 1'b1;
            end
        end
        st.pc = pc_image;
        st.x0 = reg_image[0];
        st.x1 = reg_image[1];
        st.y0 = reg_image[2];
        st.y1 = reg_image[3];
        st.carry = carry_image;
        st.zero = zero_image;
        st.halted = halt_image;
        st.cycles = cycle_image;
        return st;
    endfunction

    task automatic check_field(input string name, input longint unsigned e,
                               input longint unsigned a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, e, a);
            error_count++;
        end
    endtask

    // Predicts on every accepted input beat and checks every output beat.
    always @(posedge clk)
    begin
        stim_row_t  row;
        cpu_state_t pred;
        cpu_state_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pred = predict_cpu_step(s_tuser, s_tdata[5:0], s_tdata[14:6]);
                row = pending_rows.pop_front();
                expected_states.push_back(row.typed ? row.exp : pred);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected, actual 0x%0h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("pc", want.pc, m_tdata[5:0]);
                    check_field("x0", want.x0, m_tdata[13:6]);
                    check_field("x1", want.x1, m_tdata[21:14]);
                    check_field("y0", want.y0, m_tdata[29:22]);
                    check_field("y1", want.y1, m_tdata[37:30]);
                    check_field("carry", want.carry, m_tdata[38]);
                    check_field("zero", want.zero, m_tdata[39]);
                    check_field("halted", want.halted, m_tdata[40]);
                    check_field("cycles", want.cycles, m_tdata[72:41]);
                end
            end
        end
    end

    // Output side: random stall after each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            w = draw_wait();
            if (w != 0)
            begin
                m_tready <= 1'b0;
                ready_hold = w - 1;
            end
        end
        else if (!m_tready)
        begin
            if (ready_hold == 0)
                m_tready <= 1'b1;
            else
                ready_hold--;
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        tb_cycles++;
        if (tb_cycles > CYCLE_LIMIT)
        begin
            $display("[tiny_8bit_cpu_fetch_execute_unit] ERROR");
            $finish;
        end
    end

    // Presents one beat after a random gap and waits for its handshake.
    task automatic send_row(input stim_row_t row);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tuser <= row.op;
        s_tdata <= {1'b0, row.word, row.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
    endtask

    task automatic send_item(input logic op, input logic [5:0] addr, input logic [8:0] word);
        send_row('{op: op, addr: addr, word: word, typed: 1'b0, exp: '0});
    endtask

    // Holds the input side until every expected beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_states.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [5:0] near_pc();
        return pc_image + 6'($urandom_range(0, 2));
    endfunction

    // Stimulus.
    initial
    begin
        int         pick;
        logic [5:0] a;
        stim_row_t  step_row;
        cpu_state_t after_ldi;

        for (int i = 0; i < 64; i++)
            code_image[i] = '0;
        for (int i = 0; i < 4; i++)
            reg_image[i] = '0;
        pc_image = '0;
        alu_sel_image = t8cpu_pkg::ALU_ADD;
        bank_x_image = 1'b0;
        bank_y_image = 1'b0;
        carry_image = 1'b0;
        zero_image = 1'b1;
        halt_image = 1'b0;
        cycle_image = '0;

        step_row = '{op: t8cpu_pkg::OP_STEP, addr: '0, word: '0, typed: 1'b0, exp: '0};
        after_ldi = '{pc: 6'd2, x0: 8'hff, x1: 8'hff, y0: 8'hff, y1: 8'hff,
                      carry: 1'b1, zero: 1'b0, halted: 1'b0, cycles: 32'd1};

        // Small program: load-immediate of all ones, add with carry out, a
        // taken branch on carry, every other ALU operation, clear-carry, an
        // empty load-immediate and a jump.
        directed_rows = '{
            '{t8cpu_pkg::OP_LOAD, 6'd63, branch_word(1'b1, 1'b1, 6'd63), 1'b1, RESET_STATE},
            '{t8cpu_pkg::OP_LOAD, 6'd0,  ldi_word(4'hf), 1'b1, RESET_STATE},
            '{t8cpu_pkg::OP_LOAD, 6'd1,  9'h0ff, 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd2,
              alu_word(1'b0, 1'b0, t8cpu_pkg::ALU_ADD, t8cpu_pkg::DST_X1), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd3,  branch_word(1'b0, 1'b0, 6'd5), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd5,
              alu_word(1'b1, 1'b1, t8cpu_pkg::ALU_XOR, t8cpu_pkg::DST_Y0), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd6,
              alu_word(1'b0, 1'b1, t8cpu_pkg::ALU_AND, t8cpu_pkg::DST_Y1), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd7,
              alu_word(1'b0, 1'b0, t8cpu_pkg::ALU_OR, t8cpu_pkg::DST_X0), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd8,
              alu_word(1'b1, 1'b0, t8cpu_pkg::ALU_PASSX, t8cpu_pkg::DST_X1), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd9,
              alu_word(1'b0, 1'b0, t8cpu_pkg::ALU_PASSY, t8cpu_pkg::DST_Y0), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd10, clc_word(1'b0), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd11, ldi_word(4'h0), 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd12, 9'h000, 1'b0, '0},
            '{t8cpu_pkg::OP_LOAD, 6'd13, jump_word(6'd20), 1'b0, '0},
            '{t8cpu_pkg::OP_STEP, 6'd0,  9'h000, 1'b1, after_ldi},
            step_row, step_row, step_row, step_row, step_row,
            step_row, step_row, step_row, step_row, step_row
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        drain();

        // Fill the whole store with non-halting words, back to back.
        calm = 1'b1;
        for (int i = 0; i < 64; i++)
            send_item(t8cpu_pkg::OP_LOAD, 6'(i), safe_word());
        calm = 1'b0;

        // Random runs.
        while (item_count < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 99) == 0)
                calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_item(t8cpu_pkg::OP_STEP, 6'($urandom), 9'($urandom));
            end
            else if (pick < 84)
            begin
                a = ($urandom_range(0, 1) != 0) ? near_pc() : 6'($urandom);
                send_item(t8cpu_pkg::OP_LOAD, a, safe_word());
            end
            else if (pick < 92)
            begin
                // Any word, overwritten before it can execute.
                a = ($urandom_range(0, 1) != 0) ? near_pc() : 6'($urandom);
                send_item(t8cpu_pkg::OP_LOAD, a, 9'($urandom));
                send_item(t8cpu_pkg::OP_LOAD, a, safe_word());
            end
            else if (pick < 98)
            begin
                // Load-immediate right at the counter, then run it.
                a = pc_image;
                send_item(t8cpu_pkg::OP_LOAD, a, ldi_word(4'($urandom)));
                send_item(t8cpu_pkg::OP_LOAD, a + 6'd1,
                          CLS_BRANCH | 9'($urandom_range(0, 255)));
                send_item(t8cpu_pkg::OP_STEP, 6'($urandom), 9'($urandom));
            end
            else
            begin
                drain();
            end
        end

        // One halting word at the counter, then steps and a load while halted.
        drain();
        send_item(t8cpu_pkg::OP_LOAD, pc_image, halting_word());
        send_item(t8cpu_pkg::OP_STEP, 6'($urandom), 9'($urandom));
        send_item(t8cpu_pkg::OP_STEP, 6'($urandom), 9'($urandom));
        send_item(t8cpu_pkg::OP_LOAD, 6'($urandom), 9'($urandom));
        send_item(t8cpu_pkg::OP_STEP, 6'($urandom), 9'($urandom));

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[tiny_8bit_cpu_fetch_execute_unit] OK");
        else
            $display("[tiny_8bit_cpu_fetch_execute_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/t8cpu_pkg.sv
sv/t8cpu_ram.sv
sv/tiny_8bit_cpu_fetch_execute_unit.sv
tb/tiny_8bit_cpu_fetch_execute_unit_tb.sv
